/* rtl/hbmm_pkg.sv */
// ----------------------------------------------------------------------------
// hbmm_pkg
// shared types, codes and constants of the handheld bus memory map unit
// ----------------------------------------------------------------------------
package hbmm_pkg;

   // default sizes, used as defaults of the top level parameters
   localparam int VIDEO_RAM_BYTES_DEF = 16384;
   localparam int WORK_RAM_BYTES_DEF  = 32768;
   localparam int MAX_ROM_BANKS_DEF   = 512;

   // fixed store sizes
   localparam int SPRITE_BYTES = 160;
   localparam int HIGH_BYTES   = 127;

   // field widths
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int ROM_BANK_W = 9;
   localparam int COUNT_W    = 10;
   localparam int OUT_ADDR_W = 23;
   localparam int BANK_OFS_W = 14;
   localparam int CSR_IDX_W  = 2;

   // map boundaries
   localparam logic [ADDR_W-1:0] ADDR_ROM_BANKED = 16'h4000;
   localparam logic [ADDR_W-1:0] ADDR_VRAM       = 16'h8000;
   localparam logic [ADDR_W-1:0] ADDR_CART_RAM   = 16'hA000;
   localparam logic [ADDR_W-1:0] ADDR_WRAM       = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_OAM        = 16'hFE00;
   localparam logic [ADDR_W-1:0] ADDR_UNUSABLE   = 16'hFEA0;
   localparam logic [ADDR_W-1:0] ADDR_IO         = 16'hFF00;
   localparam logic [ADDR_W-1:0] ADDR_VBANK_SEL  = 16'hFF4F;
   localparam logic [ADDR_W-1:0] ADDR_WBANK_SEL  = 16'hFF70;
   localparam logic [ADDR_W-1:0] ADDR_HRAM       = 16'hFF80;
   localparam logic [ADDR_W-1:0] ADDR_IE         = 16'hFFFF;

   // fixed read values
   localparam logic [DATA_W-1:0] BYTE_ZERO  = 8'h00;
   localparam logic [DATA_W-1:0] BYTE_ONES  = 8'hFF;
   localparam logic [DATA_W-1:0] VBANK_FILL = 8'hFE;
   localparam logic [DATA_W-1:0] WBANK_FILL = 8'hF8;

   // bus block and screen mode codes
   localparam logic [1:0] DMA_NONE      = 2'd0;
   localparam logic [1:0] DMA_EXT       = 2'd1;
   localparam logic [1:0] DMA_VRAM      = 2'd2;
   localparam logic [1:0] LCD_MODE_XFER = 2'd3;

   // access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // reset value of the bank count register
   localparam logic [COUNT_W-1:0] ROM_BANKS_RESET = 10'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLOR_MODE    = 2'd0,
      CSR_CONSOLE_COLOR = 2'd1,
      CSR_ROM_BANKS     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      RT_HERE = 3'd0,
      RT_ROM  = 3'd1,
      RT_CART = 3'd2,
      RT_IO   = 3'd3,
      RT_DROP = 3'd4
   } route_type;

   typedef enum logic [2:0] {
      RD_FIXED = 3'd0,
      RD_VRAM  = 3'd1,
      RD_WRAM  = 3'd2,
      RD_OAM   = 3'd3,
      RD_HRAM  = 3'd4
   } rd_src_type;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'd0,
      ST_IDLE   = 3'd1,
      ST_EXEC   = 3'd2,
      ST_DIVIDE = 3'd3,
      ST_RESP   = 3'd4
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
      logic div_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_div;
   } ctrl_sts_type;

endpackage

/* rtl/handheld_bus_memory_map_unit.sv */
// ----------------------------------------------------------------------------
// handheld_bus_memory_map_unit
// memory map of a handheld console cpu bus, one byte access per item
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Each item
// gives exactly one result, shown for one cycle with rsp_valid high; there is
// no back-pressure on the result side, so the receiver must take it then.
// Steps: the request is latched, the store is accessed with its read data
// registered, then the result is shown. A read of the switchable rom window
// 4000-7fff also passes through divide steps, where the bank number is reduced
// modulo the bank count by a restoring remainder unit that retires one of the
// 9 bank bits per cycle. After reset the block runs a clearing pass that zeroes
// every store one address per cycle, covering every address of the larger
// store, with busy high; configuration writes are taken throughout, and
// csr_ready is always high. Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module handheld_bus_memory_map_unit #(
   parameter int VIDEO_RAM_BYTES = hbmm_pkg::VIDEO_RAM_BYTES_DEF,
   parameter int WORK_RAM_BYTES  = hbmm_pkg::WORK_RAM_BYTES_DEF,
   parameter int MAX_ROM_BANKS   = hbmm_pkg::MAX_ROM_BANKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [hbmm_pkg::ADDR_W-1:0]     req_address,
   input  logic [hbmm_pkg::DATA_W-1:0]     req_write_data,
   input  logic [1:0]                      req_lcd_mode,
   input  logic [1:0]                      req_dma_block,
   input  logic [hbmm_pkg::ROM_BANK_W-1:0] req_rom_bank,
   input  logic [hbmm_pkg::DATA_W-1:0]     req_dma_byte,
   // result side
   output logic                            rsp_valid,
   output logic [hbmm_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [2:0]                      rsp_route,
   output logic [hbmm_pkg::OUT_ADDR_W-1:0] rsp_outside_address,
   // configuration registers
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hbmm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hbmm_pkg::COUNT_W-1:0]    csr_wdata
);

   hbmm_pkg::ctrl_cmd_type cmd;
   hbmm_pkg::ctrl_sts_type sts;

   // register writes never wait
   assign csr_ready = 1'b1;

   // sequencer: clear pass, access, divide steps, result strobe
   hbmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // stores, decode, bank registers and the bank modulo unit
   hbmm_datapath #(
      .VIDEO_RAM_BYTES (VIDEO_RAM_BYTES),
      .WORK_RAM_BYTES  (WORK_RAM_BYTES),
      .MAX_ROM_BANKS   (MAX_ROM_BANKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .req_lcd_mode        (req_lcd_mode),
      .req_dma_block       (req_dma_block),
      .req_rom_bank        (req_rom_bank),
      .req_dma_byte        (req_dma_byte),
      .csr_write           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_read_data       (rsp_read_data),
      .rsp_route           (rsp_route),
      .rsp_outside_address (rsp_outside_address)
   );

endmodule

/* rtl/hbmm_ctrl.sv */
// ----------------------------------------------------------------------------
// hbmm_ctrl
// sequencer: clearing pass, access, bank divide steps, result strobe
// ----------------------------------------------------------------------------
module hbmm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  hbmm_pkg::ctrl_sts_type sts,
   output hbmm_pkg::ctrl_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   localparam int CTR_W = $clog2(hbmm_pkg::ROM_BANK_W + 1);
   localparam logic [CTR_W-1:0] CTR_LAST = CTR_W'(hbmm_pkg::ROM_BANK_W - 1);

   hbmm_pkg::state_type state_ff, state_in;
   logic [CTR_W-1:0]    ctr_ff, ctr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbmm_pkg::ST_CLEAR;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ctr_in   = ctr_ff;
      unique case (state_ff)
         hbmm_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = hbmm_pkg::ST_IDLE;
         end
         hbmm_pkg::ST_IDLE: begin
            if (start) state_in = hbmm_pkg::ST_EXEC;
         end
         hbmm_pkg::ST_EXEC: begin
            ctr_in = '0;
            if (sts.need_div) state_in = hbmm_pkg::ST_DIVIDE;
            else state_in = hbmm_pkg::ST_RESP;
         end
         hbmm_pkg::ST_DIVIDE: begin
            ctr_in = ctr_ff + CTR_W'(1);
            if (ctr_ff == CTR_LAST) state_in = hbmm_pkg::ST_RESP;
         end
         hbmm_pkg::ST_RESP: begin
            state_in = hbmm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hbmm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         hbmm_pkg::ST_CLEAR:  cmd.clear = 1'b1;
         hbmm_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         hbmm_pkg::ST_EXEC:   cmd.exec = 1'b1;
         hbmm_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         hbmm_pkg::ST_RESP:   rsp_valid = 1'b1;
         default:             busy = 1'b1;
      endcase
   end

endmodule

/* rtl/hbmm_datapath.sv */
// ----------------------------------------------------------------------------
// hbmm_datapath
// request latch, address decode, stores, bank registers, bank divider
// ----------------------------------------------------------------------------
module hbmm_datapath #(
   parameter int VIDEO_RAM_BYTES = hbmm_pkg::VIDEO_RAM_BYTES_DEF,
   parameter int WORK_RAM_BYTES  = hbmm_pkg::WORK_RAM_BYTES_DEF,
   parameter int MAX_ROM_BANKS   = hbmm_pkg::MAX_ROM_BANKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hbmm_pkg::ctrl_cmd_type              cmd,
   output hbmm_pkg::ctrl_sts_type              sts,
   input  logic                                req_func,
   input  logic [hbmm_pkg::ADDR_W-1:0]         req_address,
   input  logic [hbmm_pkg::DATA_W-1:0]         req_write_data,
   input  logic [1:0]                          req_lcd_mode,
   input  logic [1:0]                          req_dma_block,
   input  logic [hbmm_pkg::ROM_BANK_W-1:0]     req_rom_bank,
   input  logic [hbmm_pkg::DATA_W-1:0]         req_dma_byte,
   input  logic                                csr_write,
   input  logic [hbmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hbmm_pkg::COUNT_W-1:0]        csr_wdata,
   output logic [hbmm_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [2:0]                          rsp_route,
   output logic [hbmm_pkg::OUT_ADDR_W-1:0]     rsp_outside_address
);

   localparam int VRAM_AW   = $clog2(VIDEO_RAM_BYTES);
   localparam int WRAM_AW   = $clog2(WORK_RAM_BYTES);
   localparam int OAM_AW    = $clog2(hbmm_pkg::SPRITE_BYTES);
   localparam int HRAM_AW   = $clog2(hbmm_pkg::HIGH_BYTES);
   localparam int CLR_DEPTH = (VIDEO_RAM_BYTES > WORK_RAM_BYTES) ?
                              VIDEO_RAM_BYTES : WORK_RAM_BYTES;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int VRAM_RAW_W = hbmm_pkg::BANK_OFS_W + 1;
   localparam int WRAM_RAW_W = hbmm_pkg::BANK_OFS_W + 2;
   // compare-subtract steps that bring a banked index into the store size
   localparam int VRAM_FOLDS = (2 * 8192 - 1) / VIDEO_RAM_BYTES;
   localparam int WRAM_FOLDS = (8 * 4096 - 1) / WORK_RAM_BYTES;
   localparam logic [VRAM_RAW_W-1:0] VRAM_LIMIT = VRAM_RAW_W'(VIDEO_RAM_BYTES);
   localparam logic [WRAM_RAW_W-1:0] WRAM_LIMIT = WRAM_RAW_W'(WORK_RAM_BYTES);
   localparam logic [hbmm_pkg::COUNT_W-1:0] BANK_MAX =
      hbmm_pkg::COUNT_W'(MAX_ROM_BANKS);

   // ---- configuration ----
   logic                          color_mode_ff, color_mode_in;
   logic                          console_color_ff, console_color_in;
   logic [hbmm_pkg::COUNT_W-1:0]  bank_count_ff, bank_count_in;

   always_comb begin
      color_mode_in    = color_mode_ff;
      console_color_in = console_color_ff;
      bank_count_in    = bank_count_ff;
      if (csr_write) begin
         case (csr_index)
            hbmm_pkg::CSR_COLOR_MODE:    color_mode_in = csr_wdata[0];
            hbmm_pkg::CSR_CONSOLE_COLOR: console_color_in = csr_wdata[0];
            hbmm_pkg::CSR_ROM_BANKS:     bank_count_in = csr_wdata;
            default:                     bank_count_in = bank_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff    <= 1'b0;
         console_color_ff <= 1'b0;
         bank_count_ff    <= hbmm_pkg::ROM_BANKS_RESET;
      end else begin
         color_mode_ff    <= color_mode_in;
         console_color_ff <= console_color_in;
         bank_count_ff    <= bank_count_in;
      end
   end

   // ---- request latch ----
   logic                            func_ff;
   logic [hbmm_pkg::ADDR_W-1:0]     addr_ff;
   logic [hbmm_pkg::DATA_W-1:0]     wdata_ff;
   logic [1:0]                      mode_ff;
   logic [1:0]                      blk_ff;
   logic [hbmm_pkg::ROM_BANK_W-1:0] bank_ff;
   logic [hbmm_pkg::DATA_W-1:0]     dbyte_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         mode_ff  <= req_lcd_mode;
         blk_ff   <= req_dma_block;
         bank_ff  <= req_rom_bank;
         dbyte_ff <= req_dma_byte;
      end
   end

   // ---- bank select and interrupt enable registers ----
   logic                        vbank_ff, vbank_in;
   logic [2:0]                  wbank_ff, wbank_in;
   logic [hbmm_pkg::DATA_W-1:0] ie_ff, ie_in;

   // ---- decode ----
   hbmm_pkg::route_type         dec_route;
   hbmm_pkg::rd_src_type        dec_src;
   logic [hbmm_pkg::DATA_W-1:0] dec_fixed;
   logic dec_vram_we, dec_wram_we, dec_oam_we, dec_hram_we;
   logic dec_ie_we, dec_vbank_we, dec_wbank_we, dec_need_div;

   always_comb begin
      logic wr;
      logic ext_blk;
      logic vram_blk;
      logic oam_open;
      wr           = (func_ff == hbmm_pkg::FUNC_WRITE);
      ext_blk      = (blk_ff == hbmm_pkg::DMA_EXT);
      vram_blk     = (blk_ff == hbmm_pkg::DMA_VRAM);
      oam_open     = (blk_ff == hbmm_pkg::DMA_NONE) && !mode_ff[1];
      dec_route    = hbmm_pkg::RT_HERE;
      dec_src      = hbmm_pkg::RD_FIXED;
      dec_fixed    = hbmm_pkg::BYTE_ZERO;
      dec_vram_we  = 1'b0;
      dec_wram_we  = 1'b0;
      dec_oam_we   = 1'b0;
      dec_hram_we  = 1'b0;
      dec_ie_we    = 1'b0;
      dec_vbank_we = 1'b0;
      dec_wbank_we = 1'b0;
      dec_need_div = 1'b0;
      priority if (addr_ff < hbmm_pkg::ADDR_VRAM) begin
         priority if (ext_blk) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
            else dec_fixed = dbyte_ff;
         end else if (wr) begin
            dec_route = hbmm_pkg::RT_CART;
         end else begin
            dec_route    = hbmm_pkg::RT_ROM;
            dec_need_div = (addr_ff >= hbmm_pkg::ADDR_ROM_BANKED);
         end
      end else if (addr_ff < hbmm_pkg::ADDR_CART_RAM) begin
         priority if (vram_blk) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
            else dec_fixed = dbyte_ff;
         end else if (mode_ff == hbmm_pkg::LCD_MODE_XFER) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
            else dec_fixed = hbmm_pkg::BYTE_ONES;
         end else if (wr) begin
            dec_vram_we = 1'b1;
         end else begin
            dec_src = hbmm_pkg::RD_VRAM;
         end
      end else if (addr_ff < hbmm_pkg::ADDR_OAM) begin
         priority if (ext_blk) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
            else dec_fixed = dbyte_ff;
         end else if (addr_ff < hbmm_pkg::ADDR_WRAM) begin
            dec_route = hbmm_pkg::RT_CART;
         end else if (wr) begin
            dec_wram_we = 1'b1;
         end else begin
            dec_src = hbmm_pkg::RD_WRAM;
         end
      end else if (addr_ff < hbmm_pkg::ADDR_IO) begin
         priority if (addr_ff >= hbmm_pkg::ADDR_UNUSABLE) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
         end else if (!oam_open) begin
            if (wr) dec_route = hbmm_pkg::RT_DROP;
            else dec_fixed = hbmm_pkg::BYTE_ONES;
         end else if (wr) begin
            dec_oam_we = 1'b1;
         end else begin
            dec_src = hbmm_pkg::RD_OAM;
         end
      end else if (addr_ff < hbmm_pkg::ADDR_HRAM) begin
         priority if (addr_ff == hbmm_pkg::ADDR_VBANK_SEL) begin
            priority if (wr) begin
               if (color_mode_ff) dec_vbank_we = 1'b1;
               else dec_route = hbmm_pkg::RT_DROP;
            end else if (console_color_ff) begin
               dec_fixed = color_mode_ff ? (hbmm_pkg::VBANK_FILL | {7'd0, vbank_ff})
                                         : hbmm_pkg::VBANK_FILL;
            end else begin
               dec_fixed = hbmm_pkg::BYTE_ONES;
            end
         end else if (addr_ff == hbmm_pkg::ADDR_WBANK_SEL) begin
            if (wr) begin
               if (color_mode_ff) dec_wbank_we = 1'b1;
               else dec_route = hbmm_pkg::RT_DROP;
            end else begin
               dec_fixed = color_mode_ff ? (hbmm_pkg::WBANK_FILL | {5'd0, wbank_ff})
                                         : hbmm_pkg::BYTE_ONES;
            end
         end else begin
            dec_route = hbmm_pkg::RT_IO;
         end
      end else if (addr_ff < hbmm_pkg::ADDR_IE) begin
         if (wr) dec_hram_we = 1'b1;
         else dec_src = hbmm_pkg::RD_HRAM;
      end else begin
         if (wr) dec_ie_we = 1'b1;
         else dec_fixed = ie_ff;
      end
      // writes and routed accesses return zero
      if (wr || dec_route != hbmm_pkg::RT_HERE) begin
         dec_src   = hbmm_pkg::RD_FIXED;
         dec_fixed = hbmm_pkg::BYTE_ZERO;
      end
   end

   always_comb begin
      vbank_in = vbank_ff;
      wbank_in = wbank_ff;
      ie_in    = ie_ff;
      if (cmd.exec && dec_vbank_we) vbank_in = wdata_ff[0];
      if (cmd.exec && dec_wbank_we) wbank_in = wdata_ff[2:0];
      if (cmd.exec && dec_ie_we) ie_in = wdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbank_ff <= 1'b0;
         wbank_ff <= 3'd0;
         ie_ff    <= '0;
      end else begin
         vbank_ff <= vbank_in;
         wbank_ff <= wbank_in;
         ie_ff    <= ie_in;
      end
   end

   // ---- store indices ----
   logic [VRAM_AW-1:0] vram_idx;
   logic [WRAM_AW-1:0] wram_idx;

   always_comb begin
      logic [VRAM_RAW_W-1:0] vram_raw;
      logic [WRAM_RAW_W-1:0] wram_raw;
      logic [2:0]            wbank_eff;
      vram_raw  = {1'b0, color_mode_ff & vbank_ff, addr_ff[12:0]};
      wbank_eff = color_mode_ff ? wbank_ff : 3'd0;
      if (wbank_eff == 3'd0) wbank_eff = 3'd1;
      // echo region keeps the low 13 address bits, bit 12 picks the upper half
      if (addr_ff[12]) wram_raw = {1'b0, wbank_eff, addr_ff[11:0]};
      else wram_raw = {4'd0, addr_ff[11:0]};
      for (int k = 0; k < VRAM_FOLDS; k++) begin
         if (vram_raw >= VRAM_LIMIT) vram_raw = vram_raw - VRAM_LIMIT;
      end
      for (int k = 0; k < WRAM_FOLDS; k++) begin
         if (wram_raw >= WRAM_LIMIT) wram_raw = wram_raw - WRAM_LIMIT;
      end
      vram_idx = vram_raw[VRAM_AW-1:0];
      wram_idx = wram_raw[WRAM_AW-1:0];
   end

   // ---- clearing pass counter ----
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic             clr_vram, clr_wram, clr_oam, clr_hram;

   assign clr_in   = cmd.clear ? clr_ff + CLR_W'(1) : clr_ff;
   assign clr_vram = cmd.clear && ({1'b0, clr_ff} < (CLR_W+1)'(VIDEO_RAM_BYTES));
   assign clr_wram = cmd.clear && ({1'b0, clr_ff} < (CLR_W+1)'(WORK_RAM_BYTES));
   assign clr_oam  = cmd.clear && ({1'b0, clr_ff} < (CLR_W+1)'(hbmm_pkg::SPRITE_BYTES));
   assign clr_hram = cmd.clear && ({1'b0, clr_ff} < (CLR_W+1)'(hbmm_pkg::HIGH_BYTES));

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   assign sts.clear_done = (clr_ff == CLR_W'(CLR_DEPTH - 1));
   assign sts.need_div   = dec_need_div;

   // ---- stores ----
   logic [hbmm_pkg::DATA_W-1:0] video_ram_ff [VIDEO_RAM_BYTES];
   logic [hbmm_pkg::DATA_W-1:0] work_ram_ff [WORK_RAM_BYTES];
   logic [hbmm_pkg::DATA_W-1:0] sprite_table_ff [hbmm_pkg::SPRITE_BYTES];
   logic [hbmm_pkg::DATA_W-1:0] high_ram_ff [hbmm_pkg::HIGH_BYTES];
   logic [hbmm_pkg::DATA_W-1:0] vram_rdata_ff, wram_rdata_ff;
   logic [hbmm_pkg::DATA_W-1:0] oam_rdata_ff, hram_rdata_ff;
   logic [OAM_AW-1:0]           oam_idx;
   logic [HRAM_AW-1:0]          hram_idx;

   assign oam_idx  = addr_ff[OAM_AW-1:0];
   assign hram_idx = addr_ff[HRAM_AW-1:0];

   always_ff @(posedge clock) begin
      if (clr_vram) video_ram_ff[clr_ff[VRAM_AW-1:0]] <= '0;
      else if (cmd.exec && dec_vram_we) video_ram_ff[vram_idx] <= wdata_ff;
      if (cmd.exec) vram_rdata_ff <= video_ram_ff[vram_idx];
   end

   always_ff @(posedge clock) begin
      if (clr_wram) work_ram_ff[clr_ff[WRAM_AW-1:0]] <= '0;
      else if (cmd.exec && dec_wram_we) work_ram_ff[wram_idx] <= wdata_ff;
      if (cmd.exec) wram_rdata_ff <= work_ram_ff[wram_idx];
   end

   always_ff @(posedge clock) begin
      if (clr_oam) sprite_table_ff[clr_ff[OAM_AW-1:0]] <= '0;
      else if (cmd.exec && dec_oam_we) sprite_table_ff[oam_idx] <= wdata_ff;
      if (cmd.exec && dec_src == hbmm_pkg::RD_OAM) oam_rdata_ff <= sprite_table_ff[oam_idx];
   end

   always_ff @(posedge clock) begin
      if (clr_hram) high_ram_ff[clr_ff[HRAM_AW-1:0]] <= '0;
      else if (cmd.exec && dec_hram_we) high_ram_ff[hram_idx] <= wdata_ff;
      if (cmd.exec && dec_src == hbmm_pkg::RD_HRAM) hram_rdata_ff <= high_ram_ff[hram_idx];
   end

   // ---- bank modulo: restoring remainder, one dividend bit a step ----
   logic [hbmm_pkg::COUNT_W-1:0]    divisor;
   logic [hbmm_pkg::COUNT_W-1:0]    rem_ff, rem_in;
   logic [hbmm_pkg::ROM_BANK_W-1:0] dvd_ff, dvd_in;

   always_comb begin
      logic [hbmm_pkg::COUNT_W-1:0] trial;
      priority if (bank_count_ff == '0) divisor = hbmm_pkg::COUNT_W'(1);
      else if (bank_count_ff > BANK_MAX) divisor = BANK_MAX;
      else divisor = bank_count_ff;
      trial  = {rem_ff[hbmm_pkg::COUNT_W-2:0], dvd_ff[hbmm_pkg::ROM_BANK_W-1]};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (cmd.exec) begin
         rem_in = '0;
         dvd_in = bank_ff;
      end else if (cmd.div_step) begin
         rem_in = (trial >= divisor) ? trial - divisor : trial;
         dvd_in = {dvd_ff[hbmm_pkg::ROM_BANK_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   // ---- result ----
   hbmm_pkg::route_type         route_ff;
   hbmm_pkg::rd_src_type        src_ff;
   logic [hbmm_pkg::DATA_W-1:0] fixed_ff;
   logic                        banked_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         route_ff  <= dec_route;
         src_ff    <= dec_src;
         fixed_ff  <= dec_fixed;
         banked_ff <= dec_need_div;
      end
   end

   always_comb begin
      unique case (src_ff)
         hbmm_pkg::RD_FIXED: rsp_read_data = fixed_ff;
         hbmm_pkg::RD_VRAM:  rsp_read_data = vram_rdata_ff;
         hbmm_pkg::RD_WRAM:  rsp_read_data = wram_rdata_ff;
         hbmm_pkg::RD_OAM:   rsp_read_data = oam_rdata_ff;
         hbmm_pkg::RD_HRAM:  rsp_read_data = hram_rdata_ff;
         default:            rsp_read_data = fixed_ff;
      endcase
   end

   assign rsp_route = route_ff;
   assign rsp_outside_address = banked_ff ?
      {rem_ff[hbmm_pkg::ROM_BANK_W-1:0], addr_ff[hbmm_pkg::BANK_OFS_W-1:0]} :
      {(hbmm_pkg::OUT_ADDR_W - hbmm_pkg::ADDR_W)'(0), addr_ff};

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the handheld bus memory map unit: a directed table
// of corner accesses, then phases of random accesses under changing settings,
// every result compared field by field with a behavioral copy of the map
// ----------------------------------------------------------------------------
module testbench;
   import hbmm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 240;
   localparam int DRAIN_CYCLES   = 24;
   // the clearing pass after reset keeps busy high
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int PRINT_LIMIT    = 50;

   // dma_block value the bus never defines, blocks only the sprite table
   localparam logic [1:0] BLOCK_UNDEF = 2'd3;
   // echo region folds back onto work ram
   localparam logic [ADDR_W-1:0] ADDR_ECHO       = 16'hE000;
   localparam logic [ADDR_W-1:0] ADDR_WRAM_BANKS = 16'hD000;

   // one cpu bus access
   typedef struct packed {
      logic                  func;
      logic [ADDR_W-1:0]     address;
      logic [DATA_W-1:0]     wdata;
      logic [1:0]            lcd;
      logic [1:0]            dma;
      logic [ROM_BANK_W-1:0] bank;
      logic [DATA_W-1:0]     dbyte;
   } access_t;

   // what the map answers for one access
   typedef struct packed {
      logic [DATA_W-1:0]     rd;
      route_type             route;
      logic [OUT_ADDR_W-1:0] addr;
   } answer_t;

   // one row of the directed table: either a settings change or an access
   typedef struct packed {
      bit                 cfg;
      bit                 cm;
      bit                 cc;
      logic [COUNT_W-1:0] cnt;
      access_t            acc;
      bit                 fixed;
      answer_t            want;
   } step_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  start          = 1'b0;
   logic                  busy;
   logic                  req_func       = FUNC_READ;
   logic [ADDR_W-1:0]     req_address    = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic [1:0]            req_lcd_mode   = '0;
   logic [1:0]            req_dma_block  = DMA_NONE;
   logic [ROM_BANK_W-1:0] req_rom_bank   = '0;
   logic [DATA_W-1:0]     req_dma_byte   = '0;

   logic                  rsp_valid;
   logic [DATA_W-1:0]     rsp_read_data;
   logic [2:0]            rsp_route;
   logic [OUT_ADDR_W-1:0] rsp_outside_address;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COLOR_MODE;
   logic [COUNT_W-1:0]    csr_wdata = '0;

   // shadow of the block's stores and bank selects, all zero out of reset
   bit [DATA_W-1:0] vram_copy [VIDEO_RAM_BYTES_DEF];
   bit [DATA_W-1:0] wram_copy [WORK_RAM_BYTES_DEF];
   bit [DATA_W-1:0] oam_copy  [SPRITE_BYTES];
   bit [DATA_W-1:0] hram_copy [HIGH_BYTES];
   bit [DATA_W-1:0] ie_copy;
   bit              vbank_sel;
   bit [2:0]        wbank_sel;

   // shadow of the configuration registers, at their reset values
   bit                 color_on      = 1'b0;
   bit                 console_color = 1'b0;
   bit [COUNT_W-1:0]   bank_total    = ROM_BANKS_RESET;

   answer_t     due_answers [$];
   step_t       plan [$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned burst_left     = 0;

   handheld_bus_memory_map_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .req_lcd_mode        (req_lcd_mode),
      .req_dma_block       (req_dma_block),
      .req_rom_bank        (req_rom_bank),
      .req_dma_byte        (req_dma_byte),
      .rsp_valid           (rsp_valid),
      .rsp_read_data       (rsp_read_data),
      .rsp_route           (rsp_route),
      .rsp_outside_address (rsp_outside_address),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // behavioral memory map: works out the answer and updates the shadow stores
   function automatic answer_t predict_access(access_t a);
      answer_t     r;
      int unsigned cnt;
      int unsigned slot;
      int unsigned bank;
      int unsigned folded;
      bit          is_wr;
      is_wr  = (a.func == FUNC_WRITE);
      r.rd    = BYTE_ZERO;
      r.route = RT_HERE;
      r.addr  = OUT_ADDR_W'(a.address);
      if (a.address < ADDR_VRAM) begin
         // rom window, or the external bus held by dma
         if (a.dma == DMA_EXT) begin
            if (is_wr) r.route = RT_DROP; else r.rd = a.dbyte;
         end else if (is_wr) begin
            r.route = RT_CART;
         end else begin
            r.route = RT_ROM;
            if (a.address >= ADDR_ROM_BANKED) begin
               // bank count clamps to 1..max banks
               cnt = bank_total;
               if (cnt == 0) cnt = 1;
               if (cnt > MAX_ROM_BANKS_DEF) cnt = MAX_ROM_BANKS_DEF;
               r.addr = OUT_ADDR_W'((int'(a.bank) % cnt) * 'h4000 + int'(a.address[13:0]));
            end
         end
      end else if (a.address < ADDR_CART_RAM) begin
         // video ram
         if (a.dma == DMA_VRAM) begin
            if (is_wr) r.route = RT_DROP; else r.rd = a.dbyte;
         end else if (a.lcd == LCD_MODE_XFER) begin
            if (is_wr) r.route = RT_DROP; else r.rd = BYTE_ONES;
         end else begin
            bank = color_on ? int'(vbank_sel) : 0;
            slot = (int'(a.address) - int'(ADDR_VRAM) + 'h2000 * bank) % VIDEO_RAM_BYTES_DEF;
            if (is_wr) vram_copy[slot] = a.wdata; else r.rd = vram_copy[slot];
         end
      end else if (a.address < ADDR_OAM) begin
         // cart ram, work ram and its echo
         if (a.dma == DMA_EXT) begin
            if (is_wr) r.route = RT_DROP; else r.rd = a.dbyte;
         end else if (a.address < ADDR_WRAM) begin
            r.route = RT_CART;
         end else begin
            folded = (a.address >= ADDR_ECHO) ? int'(a.address) - 'h2000 : int'(a.address);
            bank   = color_on ? int'(wbank_sel) : 0;
            if (bank == 0) bank = 1;
            if (folded < ADDR_WRAM_BANKS)
               slot = folded - int'(ADDR_WRAM);
            else
               slot = folded - int'(ADDR_WRAM_BANKS) + 'h1000 * bank;
            slot = slot % WORK_RAM_BYTES_DEF;
            if (is_wr) wram_copy[slot] = a.wdata; else r.rd = wram_copy[slot];
         end
      end else if (a.address < ADDR_IO) begin
         if (a.address < ADDR_UNUSABLE) begin
            // sprite table, shut by any dma or by screen modes 2 and 3
            if (a.dma != DMA_NONE || a.lcd[1]) begin
               if (is_wr) r.route = RT_DROP; else r.rd = BYTE_ONES;
            end else begin
               slot = int'(a.address) - int'(ADDR_OAM);
               if (is_wr) oam_copy[slot] = a.wdata; else r.rd = oam_copy[slot];
            end
         end else if (is_wr) begin
            r.route = RT_DROP;
         end
      end else if (a.address < ADDR_HRAM) begin
         if (a.address == ADDR_VBANK_SEL) begin
            if (is_wr) begin
               if (color_on) vbank_sel = a.wdata[0]; else r.route = RT_DROP;
            end else if (console_color) begin
               r.rd = color_on ? (VBANK_FILL | DATA_W'(vbank_sel)) : VBANK_FILL;
            end else begin
               r.rd = BYTE_ONES;
            end
         end else if (a.address == ADDR_WBANK_SEL) begin
            if (is_wr) begin
               if (color_on) wbank_sel = a.wdata[2:0]; else r.route = RT_DROP;
            end else begin
               r.rd = color_on ? (WBANK_FILL | DATA_W'(wbank_sel)) : BYTE_ONES;
            end
         end else begin
            r.route = RT_IO;
         end
      end else if (a.address < ADDR_IE) begin
         slot = int'(a.address) - int'(ADDR_HRAM);
         if (is_wr) hram_copy[slot] = a.wdata; else r.rd = hram_copy[slot];
      end else begin
         if (is_wr) ie_copy = a.wdata; else r.rd = ie_copy;
      end
      // read data only shows on reads served here
      if (is_wr || r.route != RT_HERE) r.rd = BYTE_ZERO;
      return r;
   endfunction

   // directed row with its answer typed in
   function automatic step_t acc_step(logic func, logic [ADDR_W-1:0] address,
                                      logic [DATA_W-1:0] wdata, logic [1:0] lcd,
                                      logic [1:0] dma, logic [DATA_W-1:0] dbyte,
                                      logic [ROM_BANK_W-1:0] bank, bit fixed,
                                      logic [DATA_W-1:0] rd, route_type route,
                                      logic [OUT_ADDR_W-1:0] out_addr);
      step_t s;
      s             = '0;
      s.acc.func    = func;
      s.acc.address = address;
      s.acc.wdata   = wdata;
      s.acc.lcd     = lcd;
      s.acc.dma     = dma;
      s.acc.dbyte   = dbyte;
      s.acc.bank    = bank;
      s.fixed       = fixed;
      s.want.rd     = rd;
      s.want.route  = route;
      s.want.addr   = out_addr;
      return s;
   endfunction

   // directed row left to the behavioral map
   function automatic step_t pred_step(logic func, logic [ADDR_W-1:0] address,
                                       logic [DATA_W-1:0] wdata, logic [1:0] lcd,
                                       logic [1:0] dma);
      return acc_step(func, address, wdata, lcd, dma, 8'h00, 9'h000, 1'b0,
                      BYTE_ZERO, RT_HERE, '0);
   endfunction

   function automatic step_t cfg_step(bit cm, bit cc, logic [COUNT_W-1:0] cnt);
      step_t s;
      s     = '0;
      s.cfg = 1'b1;
      s.cm  = cm;
      s.cc  = cc;
      s.cnt = cnt;
      return s;
   endfunction

   // mostly short gaps, a few long ones, and bursts with none at all
   function automatic int unsigned next_gap();
      int unsigned roll;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // video and work ram addresses lean toward the start and end of each 4K page so reads hit written bytes
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] near;
      int unsigned       zone;
      near = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 15))
                                  : ADDR_W'($urandom_range('h0FF0, 'h0FFF));
      zone = $urandom_range(0, 13);
      case (zone)
         0, 1: return ADDR_W'($urandom);
         2: return ADDR_W'($urandom_range(0, 'h7FFF));
         3: return ADDR_VRAM + ($urandom_range(0, 1) ? near + 'h1000 * $urandom_range(0, 1)
                                                      : ADDR_W'($urandom_range(0, 'h1FFF)));
         4: return ADDR_WRAM + near;
         5: return ADDR_WRAM_BANKS + near;
         6: return ADDR_ECHO + near + 'h1000 * $urandom_range(0, 1);
         7: return ADDR_OAM + ADDR_W'($urandom_range(0, 'hFF));
         8: return ADDR_IO + ADDR_W'($urandom_range(0, 'h7F));
         9, 10: return ADDR_VBANK_SEL;
         11: return ADDR_WBANK_SEL;
         12: return ADDR_HRAM + ADDR_W'($urandom_range(0, 'h7F));
         default: return ADDR_CART_RAM + ADDR_W'($urandom_range(0, 'h1FFF));
      endcase
   endfunction

   // random access: mostly open bus and visible screen modes so the stores fill up
   function automatic access_t random_access();
      access_t     a;
      int unsigned roll;
      a.func    = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      a.address = pick_address();
      a.wdata   = $urandom;
      a.bank    = $urandom;
      a.dbyte   = $urandom;
      roll      = $urandom_range(0, 9);
      a.lcd     = (roll < 7) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
      roll      = $urandom_range(0, 19);
      if (roll < 13)      a.dma = DMA_NONE;
      else if (roll < 15) a.dma = DMA_EXT;
      else if (roll < 18) a.dma = DMA_VRAM;
      else                a.dma = BLOCK_UNDEF;
      return a;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned wanted);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0h wanted %0h", $time, field, got, wanted);
      mismatch_count++;
   endtask

   // present one access, hold it until taken, then idle for a random gap, which may be none
   task automatic issue_access(input access_t a, input bit fixed, input answer_t want);
      answer_t     model;
      int unsigned gap;
      start          <= 1'b1;
      req_func       <= a.func;
      req_address    <= a.address;
      req_write_data <= a.wdata;
      req_lcd_mode   <= a.lcd;
      req_dma_block  <= a.dma;
      req_rom_bank   <= a.bank;
      req_dma_byte   <= a.dbyte;
      do @(posedge clock); while (busy);
      // the shadow stores advance on every item, typed-in rows included
      model = predict_access(a);
      due_answers.push_back(fixed ? want : model);
      gap = next_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every outstanding answer is back
   task automatic settle_pending();
      start <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
   endtask

   // write all three registers back to back, valid stays high in between
   task automatic apply_settings(bit cm, bit cc, logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0] value [3];
      value[CSR_COLOR_MODE]    = COUNT_W'(cm);
      value[CSR_CONSOLE_COLOR] = COUNT_W'(cc);
      value[CSR_ROM_BANKS]     = cnt;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid     <= 1'b0;
      color_on      = cm;
      console_color = cc;
      bank_total    = cnt;
   endtask

   // result side: no back-pressure, so every strobe is an answer to check
   always @(posedge clock) begin : answer_check
      answer_t want;
      if (!reset && rsp_valid) begin
         if (due_answers.size() == 0) begin
            report_mismatch("result with nothing pending, route", rsp_route, 0);
         end else begin
            want = due_answers.pop_front();
            if (rsp_read_data !== want.rd)
               report_mismatch("read_data", rsp_read_data, want.rd);
            if (rsp_route !== want.route)
               report_mismatch("route", rsp_route, want.route);
            if (rsp_outside_address !== want.addr)
               report_mismatch("outside_address", rsp_outside_address, want.addr);
         end
      end
   end

   // watchdog: counts cycles with no handshake on any side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      plan = '{
         // reset settings: monochrome game, monochrome console, two rom banks
         acc_step(FUNC_READ,  16'h0000, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_ROM,  23'h000000),
         // bank 511 mod 2 lands on bank 1
         acc_step(FUNC_READ,  16'h7FFF, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h1FF,
                  1'b1, 8'h00, RT_ROM,  23'h007FFF),
         // bank registers outside color mode
         acc_step(FUNC_READ,  16'hFF4F, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FF4F),
         acc_step(FUNC_READ,  16'hFF70, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FF70),
         acc_step(FUNC_WRITE, 16'hFF4F, 8'h01, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_DROP, 23'h00FF4F),
         // video ram reads zero after reset, then interrupt enable write and readback
         acc_step(FUNC_READ,  16'h8000, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_HERE, 23'h008000),
         acc_step(FUNC_WRITE, 16'hFFFF, 8'hFF, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_HERE, 23'h00FFFF),
         acc_step(FUNC_READ,  16'hFFFF, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FFFF),
         // color mode on a color console, bank count zero counts as one
         cfg_step(1'b1, 1'b1, 10'd0),
         acc_step(FUNC_READ,  16'h4000, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h1FF,
                  1'b1, 8'h00, RT_ROM,  23'h000000),
         acc_step(FUNC_WRITE, 16'hFF4F, 8'hFF, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_HERE, 23'h00FF4F),
         acc_step(FUNC_READ,  16'hFF4F, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FF4F),
         acc_step(FUNC_READ,  16'hFF70, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hF8, RT_HERE, 23'h00FF70),
         // work ram bank 0 selects bank 1, read back through the echo
         pred_step(FUNC_WRITE, 16'hD000, 8'hA5, 2'd1, DMA_NONE),
         pred_step(FUNC_READ,  16'hF000, 8'h00, 2'd0, DMA_NONE),
         // top byte of video bank 1
         pred_step(FUNC_WRITE, 16'h9FFF, 8'h5A, 2'd0, DMA_NONE),
         pred_step(FUNC_READ,  16'h9FFF, 8'h00, 2'd1, DMA_NONE),
         // video ram shut during pixel transfer
         acc_step(FUNC_READ,  16'h8000, 8'h00, LCD_MODE_XFER, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h008000),
         // video ram under dma gives the dma byte
         acc_step(FUNC_READ,  16'h9000, 8'h00, 2'd0, DMA_VRAM, 8'h3C, 9'h000,
                  1'b1, 8'h3C, RT_HERE, 23'h009000),
         // external bus under dma
         acc_step(FUNC_READ,  16'h0100, 8'h00, 2'd0, DMA_EXT, 8'hC3, 9'h000,
                  1'b1, 8'hC3, RT_HERE, 23'h000100),
         acc_step(FUNC_WRITE, 16'hA000, 8'h77, 2'd0, DMA_EXT, 8'hC3, 9'h000,
                  1'b1, 8'h00, RT_DROP, 23'h00A000),
         // sprite table shut by screen mode 2 and by the undefined block code
         acc_step(FUNC_READ,  16'hFE00, 8'h00, 2'd2, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FE00),
         acc_step(FUNC_WRITE, 16'hFE9F, 8'h11, 2'd0, BLOCK_UNDEF, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_DROP, 23'h00FE9F),
         // unusable region
         acc_step(FUNC_READ,  16'hFEFF, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_HERE, 23'h00FEFF),
         acc_step(FUNC_WRITE, 16'hFEA0, 8'h22, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_DROP, 23'h00FEA0),
         // routed out: other i/o, cart ram, controller writes
         acc_step(FUNC_WRITE, 16'hFF00, 8'h33, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_IO,   23'h00FF00),
         acc_step(FUNC_READ,  16'hBFFF, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_CART, 23'h00BFFF),
         acc_step(FUNC_WRITE, 16'h2000, 8'h01, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'h00, RT_CART, 23'h002000),
         // high ram ends
         pred_step(FUNC_WRITE, 16'hFF80, 8'h81, 2'd3, DMA_NONE),
         pred_step(FUNC_WRITE, 16'hFFFE, 8'h7E, 2'd0, DMA_NONE),
         pred_step(FUNC_READ,  16'hFF80, 8'h00, 2'd0, DMA_NONE),
         // bank count above the maximum clamps, monochrome console readback
         cfg_step(1'b1, 1'b0, 10'h3FF),
         acc_step(FUNC_READ,  16'h4000, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h1FF,
                  1'b1, 8'h00, RT_ROM,  23'h7FC000),
         acc_step(FUNC_READ,  16'hFF4F, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFF, RT_HERE, 23'h00FF4F),
         // monochrome game on a color console, full bank count
         cfg_step(1'b0, 1'b1, 10'd512),
         acc_step(FUNC_READ,  16'hFF4F, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h000,
                  1'b1, 8'hFE, RT_HERE, 23'h00FF4F),
         acc_step(FUNC_READ,  16'h7FFF, 8'h00, 2'd0, DMA_NONE, 8'h00, 9'h1FF,
                  1'b1, 8'h00, RT_ROM,  23'h7FFFFF)
      };

      // synchronous reset, once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table: settings rows wait for the block to go quiet
      foreach (plan[i]) begin
         if (plan[i].cfg) begin
            settle_pending();
            apply_settings(plan[i].cm, plan[i].cc, plan[i].cnt);
         end else begin
            issue_access(plan[i].acc, plan[i].fixed, plan[i].want);
         end
      end

      // random phases, each under its own settings, extremes first
      for (int p = 0; p < PHASES; p++) begin
         settle_pending();
         case (p)
            0: apply_settings(1'b1, 1'b1, 10'd0);
            1: apply_settings(1'b1, 1'b0, 10'h3FF);
            2: apply_settings(1'b0, 1'b1, 10'd512);
            3: apply_settings(1'b1, 1'b1, 10'd1);
            4: apply_settings(1'b0, 1'b0, 10'd513);
            default: apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                                    COUNT_W'($urandom_range(0, 1023)));
         endcase
         repeat (PHASE_ITEMS) issue_access(random_access(), 1'b0, '0);
      end

      // drain, then a few more cycles to catch stray strobes
      settle_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* files.f */
rtl/hbmm_pkg.sv
rtl/hbmm_ctrl.sv
rtl/hbmm_datapath.sv
rtl/handheld_bus_memory_map_unit.sv
test/testbench.sv
